>>> rtl/core/smx_pkg.sv
// ----------------------------------------------------------------------------
// smx_pkg
// Shared types and constants of the stack machine execute unit.
// ----------------------------------------------------------------------------
package smx_pkg;

  // Default sizes
  localparam int unsigned StackDepthDefault = 1024;
  localparam int unsigned FrameDepthDefault = 64;
  localparam logic [31:0] CodeBytes         = 32'd65536;

  // Instruction codes
  typedef enum logic [7:0] {
    OP_ADD   = 8'd0,
    OP_MUL   = 8'd1,
    OP_DIV   = 8'd2,
    OP_MOD   = 8'd3,
    OP_EQ    = 8'd4,
    OP_GT    = 8'd5,
    OP_GE    = 8'd6,
    OP_LT    = 8'd7,
    OP_LE    = 8'd8,
    OP_AND   = 8'd9,
    OP_OR    = 8'd10,
    OP_NOT   = 8'd11,
    OP_NEG   = 8'd12,
    OP_JMP   = 8'd13,
    OP_JF    = 8'd14,
    OP_STORE = 8'd15,
    OP_LOAD  = 8'd16,
    OP_PUSH  = 8'd17,
    OP_POP   = 8'd18,
    OP_HALT  = 8'd19,
    OP_CALL  = 8'd20,
    OP_PRINT = 8'd22,
    OP_RET   = 8'd24
  } opcode_e;

  // Run state / status codes
  typedef enum logic [2:0] {
    ST_RUN     = 3'd0,
    ST_HALT    = 3'd1,
    ST_ILLEGAL = 3'd2,
    ST_FRAME   = 3'd3,
    ST_OVER    = 3'd4,
    ST_UNDER   = 3'd5,
    ST_CODE    = 3'd6,
    ST_DIV     = 3'd7
  } status_e;

  // Item modes
  localparam logic ModeStart = 1'b0;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RD1,
    S_RD2,
    S_ALU,
    S_DIV,
    S_WR,
    S_RESP
  } state_e;

  typedef struct packed {
    logic               mode;
    logic [7:0]         opcode;
    logic signed [31:0] immediate;
  } smx_in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [15:0]        next_ip;
    logic               print_valid;
    logic signed [31:0] print_value;
  } smx_out_t;

endpackage

>>> rtl/core/stack_machine_execute_unit.sv
// ----------------------------------------------------------------------------
// stack_machine_execute_unit
// Executes one stack machine instruction per input transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i) carries a start item
//   (mode 0, entry address in immediate) or an execute item (opcode plus
//   immediate). Each transaction gives exactly one result transaction on
//   out_valid_o/out_ready_i/out_data_o: status, next fetch address and an
//   optional printed value.
//   One item is in flight at a time; in_ready_o is high while idle, also
//   while a previous result still waits in the output register.
//   Start, jumps, push, pop, halt, call and faults found at decode finish
//   in S_EXEC; single-operand ops, print, load and store also pass S_RD1;
//   ret passes S_RD1 and S_RD2; two-operand ops pass S_RD1, S_RD2, S_ALU
//   and S_WR (a divide fault leaves S_ALU for S_RESP), and div and mod
//   wait in S_DIV between S_ALU and S_WR. The sequencer returns to S_IDLE
//   as it registers the result. The single port of the stack memory (one
//   access per cycle) and the bit-serial divider lead to these steps.
//   After reset the machine is halted with all pointers at zero; the stack
//   memory holds no defined data. A stalled receiver holds the result in
//   the output register and the sequencer waits before its next result.
// ----------------------------------------------------------------------------
module stack_machine_execute_unit
  import smx_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = StackDepthDefault,
  parameter int unsigned FRAME_DEPTH = FrameDepthDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  smx_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output smx_out_t out_data_o
);

  localparam int unsigned AW  = $clog2(STACK_DEPTH);
  localparam int unsigned SW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned FAW = $clog2(FRAME_DEPTH);
  localparam int unsigned FCW = $clog2(FRAME_DEPTH + 1);
  localparam logic [SW-1:0]  StackFull = SW'(STACK_DEPTH);
  localparam logic [FCW-1:0] FrameFull = FCW'(FRAME_DEPTH);
  localparam logic [32:0]    StackLim  = 33'(STACK_DEPTH);

  // Architectural and sequencing registers
  state_e          state_q, state_d;
  status_e         run_q, run_d;
  logic [SW-1:0]   top_q, top_d, fb_q, fb_d;
  logic [FCW-1:0]  fc_q, fc_d;
  logic [31:0]     cp_q, cp_d;
  logic            out_valid_q, out_valid_d;
  logic            pflag_q, pflag_d;
  // Payload registers
  logic            mode_q, mode_d;
  logic [7:0]      op_q, op_d;
  logic [31:0]     imm_q, imm_d, a_q, a_d, b_q, b_d, c_q, c_d;
  smx_out_t        out_q, out_d;

  // Memory ports
  logic            st_en, st_we;
  logic [AW-1:0]   st_addr;
  logic [31:0]     st_wdata, st_rdata;
  logic            fr_en, fr_we;
  logic [FAW-1:0]  fr_addr;
  logic [SW-1:0]   fr_rdata;

  // Divider
  logic            div_start, div_done;
  logic [31:0]     div_quo, div_rem, a_mag, b_mag;

  // Derived values
  opcode_e         op_e;
  logic            has_imm, code_fault;
  logic [31:0]     nip;
  logic [SW-1:0]   top_m1, top_m2, top_p1;
  logic [33:0]     loc;
  logic            loc_under, loc_over;
  logic [AW-1:0]   loc_idx;
  logic [31:0]     mul_lo;

  smx_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
    .clk_i   (clk_i),
    .en_i    (st_en),
    .we_i    (st_we),
    .addr_i  (st_addr),
    .wdata_i (st_wdata),
    .rdata_o (st_rdata)
  );

  smx_ram #(.WIDTH(SW), .DEPTH(FRAME_DEPTH)) u_frames (
    .clk_i   (clk_i),
    .en_i    (fr_en),
    .we_i    (fr_we),
    .addr_i  (fr_addr),
    .wdata_i (fb_q),
    .rdata_o (fr_rdata)
  );

  assign a_mag = a_q[31] ? (32'd0 - a_q) : a_q;
  assign b_mag = b_q[31] ? (32'd0 - b_q) : b_q;

  smx_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (a_mag),
    .divisor_i  (b_mag),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  // Decode and address arithmetic
  assign op_e       = opcode_e'(op_q);
  assign has_imm    = op_e inside {OP_JMP, OP_JF, OP_STORE, OP_LOAD, OP_PUSH, OP_CALL};
  assign code_fault = (cp_q >= CodeBytes) || (has_imm && ((cp_q + 32'd1) >= CodeBytes));
  assign nip        = cp_q + (has_imm ? 32'd5 : 32'd1);
  assign top_m1     = top_q - SW'(1);
  assign top_m2     = top_q - SW'(2);
  assign top_p1     = top_q + SW'(1);
  assign loc        = {{(34 - SW){1'b0}}, fb_q} + {{2{imm_q[31]}}, imm_q};
  assign loc_under  = loc[33];
  assign loc_over   = !loc[33] && (loc[32:0] >= StackLim);
  assign loc_idx    = loc[AW-1:0];
  assign mul_lo     = a_q * b_q;

  // Sequencer: next state, register updates and memory control
  always_comb begin
    state_d     = state_q;
    run_d       = run_q;
    top_d       = top_q;
    fb_d        = fb_q;
    fc_d        = fc_q;
    cp_d        = cp_q;
    pflag_d     = pflag_q;
    mode_d      = mode_q;
    op_d        = op_q;
    imm_d       = imm_q;
    a_d         = a_q;
    b_d         = b_q;
    c_d         = c_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    st_en       = 1'b0;
    st_we       = 1'b0;
    st_addr     = top_m1[AW-1:0];
    st_wdata    = '0;
    fr_en       = 1'b0;
    fr_we       = 1'b0;
    fr_addr     = fc_q[FAW-1:0];
    div_start   = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          mode_d  = in_data_i.mode;
          op_d    = in_data_i.opcode;
          imm_d   = in_data_i.immediate;
          pflag_d = 1'b0;
          c_d     = '0;
          state_d = S_EXEC;
        end
      end

      // Fault checks and first memory access
      S_EXEC: begin
        state_d = S_RESP;
        if (mode_q == ModeStart) begin
          top_d = '0;
          fb_d  = '0;
          fc_d  = '0;
          cp_d  = imm_q;
          run_d = ST_RUN;
        end else if (run_q != ST_RUN) begin
          state_d = S_RESP;
        end else if (code_fault) begin
          run_d = ST_CODE;
        end else begin
          case (op_e)
            OP_ADD, OP_MUL, OP_DIV, OP_MOD, OP_EQ, OP_GT, OP_GE, OP_LT, OP_LE, OP_AND,
            OP_OR: begin
              if (top_q < SW'(2)) begin
                run_d = ST_UNDER;
              end else begin
                st_en   = 1'b1;
                state_d = S_RD1;
              end
            end
            OP_NOT, OP_NEG, OP_JF, OP_PRINT: begin
              if (top_q == '0) begin
                run_d = ST_UNDER;
              end else begin
                st_en   = 1'b1;
                state_d = S_RD1;
              end
            end
            OP_STORE: begin
              if (top_q == '0) begin
                run_d = ST_UNDER;
              end else if (loc_under) begin
                run_d = ST_UNDER;
              end else if (loc_over) begin
                run_d = ST_OVER;
              end else begin
                st_en   = 1'b1;
                state_d = S_RD1;
              end
            end
            OP_LOAD: begin
              if (loc_under) begin
                run_d = ST_UNDER;
              end else if (loc_over || top_q >= StackFull) begin
                run_d = ST_OVER;
              end else begin
                st_en   = 1'b1;
                st_addr = loc_idx;
                state_d = S_RD1;
              end
            end
            OP_JMP: begin
              cp_d = imm_q;
            end
            OP_PUSH: begin
              if (top_q >= StackFull) begin
                run_d = ST_OVER;
              end else begin
                st_en    = 1'b1;
                st_we    = 1'b1;
                st_addr  = top_q[AW-1:0];
                st_wdata = imm_q;
                top_d    = top_p1;
                cp_d     = nip;
              end
            end
            OP_POP: begin
              if (top_q == '0) begin
                run_d = ST_UNDER;
              end else begin
                top_d = top_m1;
                cp_d  = nip;
              end
            end
            OP_HALT: begin
              run_d = ST_HALT;
              cp_d  = nip;
            end
            OP_CALL: begin
              if (top_q >= StackFull) begin
                run_d = ST_OVER;
              end else if (fc_q >= FrameFull) begin
                run_d = ST_FRAME;
              end else begin
                st_en    = 1'b1;
                st_we    = 1'b1;
                st_addr  = top_q[AW-1:0];
                st_wdata = nip;
                fr_en    = 1'b1;
                fr_we    = 1'b1;
                fc_d     = fc_q + FCW'(1);
                top_d    = top_p1;
                fb_d     = top_p1;
                cp_d     = imm_q;
              end
            end
            OP_RET: begin
              if (top_q < SW'(2)) begin
                run_d = ST_UNDER;
              end else if (fc_q == '0) begin
                run_d = ST_FRAME;
              end else begin
                st_en   = 1'b1;
                fr_en   = 1'b1;
                fr_addr = FAW'(fc_q - FCW'(1));
                state_d = S_RD1;
              end
            end
            default: begin
              run_d = ST_ILLEGAL;
            end
          endcase
        end
      end

      // Top of stack (or load source) arrives
      S_RD1: begin
        b_d     = st_rdata;
        state_d = S_RESP;
        case (op_e)
          OP_NOT, OP_NEG: begin
            st_en    = 1'b1;
            st_we    = 1'b1;
            st_wdata = (op_e == OP_NOT) ? (32'd1 - st_rdata) : (32'd0 - st_rdata);
            cp_d     = nip;
          end
          OP_JF: begin
            top_d = top_m1;
            cp_d  = (st_rdata == '0) ? imm_q : nip;
          end
          OP_STORE: begin
            st_en    = 1'b1;
            st_we    = 1'b1;
            st_addr  = loc_idx;
            st_wdata = st_rdata;
            top_d    = (SW'(loc_idx) >= top_m1) ? (SW'(loc_idx) + SW'(1)) : top_m1;
            cp_d     = nip;
          end
          OP_LOAD: begin
            st_en    = 1'b1;
            st_we    = 1'b1;
            st_addr  = top_q[AW-1:0];
            st_wdata = st_rdata;
            top_d    = top_p1;
            cp_d     = nip;
          end
          OP_PRINT: begin
            top_d   = top_m1;
            c_d     = st_rdata;
            pflag_d = 1'b1;
            cp_d    = nip;
          end
          default: begin
            // two-operand ops and ret fetch the second entry
            st_en   = 1'b1;
            st_addr = top_m2[AW-1:0];
            state_d = S_RD2;
          end
        endcase
      end

      // Second entry arrives
      S_RD2: begin
        if (op_e == OP_RET) begin
          st_en    = 1'b1;
          st_we    = 1'b1;
          st_addr  = top_m2[AW-1:0];
          st_wdata = b_q;
          top_d    = top_m1;
          fc_d     = fc_q - FCW'(1);
          fb_d     = fr_rdata;
          cp_d     = st_rdata;
          state_d  = S_RESP;
        end else begin
          a_d     = st_rdata;
          state_d = S_ALU;
        end
      end

      // Two-operand result
      S_ALU: begin
        state_d = S_WR;
        case (op_e)
          OP_ADD: c_d = a_q + b_q;
          OP_MUL: c_d = mul_lo;
          OP_DIV, OP_MOD: begin
            if (b_q == '0 || (a_q == 32'h8000_0000 && b_q == 32'hFFFF_FFFF)) begin
              run_d   = ST_DIV;
              state_d = S_RESP;
            end else begin
              div_start = 1'b1;
              state_d   = S_DIV;
            end
          end
          OP_EQ:  c_d = {31'd0, a_q == b_q};
          OP_GT:  c_d = {31'd0, $signed(b_q) < $signed(a_q)};
          OP_GE:  c_d = {31'd0, !($signed(a_q) < $signed(b_q))};
          OP_LT:  c_d = {31'd0, $signed(a_q) < $signed(b_q)};
          OP_LE:  c_d = {31'd0, !($signed(b_q) < $signed(a_q))};
          OP_AND: c_d = {31'd0, (a_q != '0) && (b_q != '0)};
          default: c_d = {31'd0, (a_q != '0) || (b_q != '0)};
        endcase
      end

      // Wait for the divider, then fix signs
      S_DIV: begin
        if (div_done) begin
          if (op_e == OP_DIV) begin
            c_d = (a_q[31] ^ b_q[31]) ? (32'd0 - div_quo) : div_quo;
          end else begin
            c_d = a_q[31] ? (32'd0 - div_rem) : div_rem;
          end
          state_d = S_WR;
        end
      end

      // Write back the two-operand result
      S_WR: begin
        st_en    = 1'b1;
        st_we    = 1'b1;
        st_addr  = top_m2[AW-1:0];
        st_wdata = c_q;
        top_d    = top_m1;
        cp_d     = nip;
        state_d  = S_RESP;
      end

      // Hand the result to the output register
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.status      = run_q;
          out_d.next_ip     = cp_q[15:0];
          out_d.print_valid = pflag_q;
          out_d.print_value = pflag_q ? c_q : '0;
          out_valid_d       = 1'b1;
          state_d           = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      run_q       <= ST_HALT;
      top_q       <= '0;
      fb_q        <= '0;
      fc_q        <= '0;
      cp_q        <= '0;
      out_valid_q <= 1'b0;
      pflag_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      run_q       <= run_d;
      top_q       <= top_d;
      fb_q        <= fb_d;
      fc_q        <= fc_d;
      cp_q        <= cp_d;
      out_valid_q <= out_valid_d;
      pflag_q     <= pflag_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;
    op_q   <= op_d;
    imm_q  <= imm_d;
    a_q    <= a_d;
    b_q    <= b_d;
    c_q    <= c_d;
    out_q  <= out_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> rtl/core/smx_ram.sv
// ----------------------------------------------------------------------------
// smx_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module smx_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write, or read into the output register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_o <= mem_q[addr_i];
      end
    end
  end

endmodule

>>> rtl/core/smx_div.sv
// ----------------------------------------------------------------------------
// smx_div
// Unsigned 32-bit restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module smx_div
  import smx_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quo_o,
  output logic [31:0] rem_o
);

  logic        busy_q, done_q;
  logic [4:0]  cnt_q;
  logic [31:0] rem_q, quo_q, dvs_q;
  logic [32:0] shift, diff;

  // One shift-subtract step
  assign shift = {rem_q, quo_q[31]};
  assign diff  = shift - {1'b0, dvs_q};

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      if (!diff[32]) begin
        rem_q <= diff[31:0];
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= shift[31:0];
        quo_q <= {quo_q[30:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

>>> rtl/core/smx_checker.sv
// ----------------------------------------------------------------------------
// smx_checker
// Port-level assertions for the stack machine execute unit.
// ----------------------------------------------------------------------------
module smx_checker
  import smx_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input smx_in_t  in_data_i,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input smx_out_t out_data_o
);

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // One transaction in flight at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted twice back to back");

  // No print value without print
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.print_valid |-> out_data_o.print_value == '0)
    else $error("stray print value");

  // A print only completes in the running state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.print_valid |-> out_data_o.status == ST_RUN)
    else $error("print reported with a non-running status");

endmodule

bind stack_machine_execute_unit smx_checker u_smx_checker (.*);
